// ----- rtl/core/cip_pkg.sv -----
// Shared types and constants for the chain interval projector.
// Used by cip_ctrl, cip_dp and chain_interval_projector.
package cip_pkg;

  localparam int MaxRegions = 32;
  localparam int MaxFlank = 15;
  localparam int HistDepth = MaxFlank + 2;
  localparam int CoordW = 31;
  localparam int SlotW = 5;
  localparam logic [CoordW-1:0] MaxV = {CoordW{1'b1}};

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_BLOCK  = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_FLANK  = 3'd0,
    REG_COUNT  = 3'd1,
    REG_TSTART = 3'd2,
    REG_TEND   = 3'd3,
    REG_QSTART = 3'd4,
    REG_QEND   = 3'd5,
    REG_QLEN   = 3'd6,
    REG_QFWD   = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLOCK,
    ST_SCAN,
    ST_REPORT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SlotW-1:0]  region_slot;
    logic [CoordW-1:0] region_begin;
    logic [CoordW-1:0] region_finish;
    logic              same_chromosome;
    logic [CoordW-1:0] block_length;
    logic [CoordW-1:0] target_gap;
    logic [CoordW-1:0] query_gap;
  } in_item_t;

  typedef struct packed {
    logic [SlotW-1:0]  region_number;
    logic [CoordW-1:0] projected_start;
    logic [CoordW-1:0] projected_end;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic [3:0]        flank;
    logic [5:0]        count;
    logic [CoordW-1:0] tstart;
    logic [CoordW-1:0] tend;
    logic [CoordW-1:0] qstart;
    logic [CoordW-1:0] qend;
    logic [CoordW-1:0] qlen;
    logic              qfwd;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;
    logic             block;
    logic             scan;
    logic             report;
    logic             clear;
    logic [SlotW-1:0] idx;
  } cmd_t;

  function automatic logic [CoordW-1:0] sat_add(input logic [CoordW-1:0] a,
                                                input logic [CoordW-1:0] b);
    logic [CoordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CoordW] ? MaxV : s[CoordW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] sat_sub(input logic [CoordW-1:0] a,
                                                input logic [CoordW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

endpackage

// ----- rtl/core/cip_ctrl.sv -----
// Sequencer for the chain interval projector: accepts items, walks regions.
// Depends on cip_pkg; drives cip_dp through cmd_t.
module cip_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [1:0]                  in_mode,
  output logic                        in_stall,
  input  logic [5:0]                  count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_last,
  output cip_pkg::cmd_t               cmd
);

  cip_pkg::state_t state, state_next;
  logic [cip_pkg::SlotW-1:0] idx, idx_next;
  logic [5:0] n;
  logic       idx_last;

  assign n = (count > 6'(cip_pkg::MaxRegions)) ? 6'(cip_pkg::MaxRegions) : count;
  assign idx_last = (6'(idx) + 6'd1 >= n);
  assign in_stall = (state != cip_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cip_pkg::ST_IDLE;
      idx <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    cmd = '0;
    cmd.idx = idx;
    out_valid = 1'b0;
    out_last = idx_last;
    unique case (state)
      cip_pkg::ST_IDLE: begin
        idx_next = '0;
        if (in_valid) begin
          unique case (cip_pkg::mode_t'(in_mode))
            cip_pkg::MODE_LOAD: cmd.load = 1'b1;
            cip_pkg::MODE_BLOCK: begin
              cmd.block = 1'b1;
              state_next = cip_pkg::ST_BLOCK;
            end
            cip_pkg::MODE_FINISH:
              state_next = (n == 6'd0) ? cip_pkg::ST_CLEAR : cip_pkg::ST_REPORT;
            default: ;
          endcase
        end
      end
      cip_pkg::ST_BLOCK: begin
        // history and cursors are settled; sweep regions next unless the count is zero
        state_next = (n == 6'd0) ? cip_pkg::ST_IDLE : cip_pkg::ST_SCAN;
      end
      cip_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        idx_next = idx + 1'b1;
        if (idx_last) state_next = cip_pkg::ST_IDLE;
      end
      cip_pkg::ST_REPORT: begin
        cmd.report = 1'b1;
        out_valid = 1'b1;
        if (!out_stall) begin
          idx_next = idx + 1'b1;
          if (idx_last) state_next = cip_pkg::ST_CLEAR;
        end
      end
      cip_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_next = cip_pkg::ST_IDLE;
      end
      default: state_next = cip_pkg::ST_IDLE;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.block, cmd.scan, cmd.report, cmd.clear}))
    else $error("multiple commands");
  a_clear_after_report: assert property (@(posedge clk) disable iff (rst)
    (state == cip_pkg::ST_REPORT && !out_stall && idx_last) |=> cmd.clear)
    else $error("report not followed by clear");
  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (6'(idx) < n))
    else $error("scan beyond count");

endmodule

// ----- rtl/core/cip_dp.sv -----
// Datapath of the chain interval projector: region table, cursors, history.
// Depends on cip_pkg; commanded by cip_ctrl.
module cip_dp (
  input  logic                clk,
  input  logic                rst,
  input  cip_pkg::cmd_t       cmd,
  input  cip_pkg::cfg_t       cfg,
  input  cip_pkg::in_item_t   item,
  input  logic                last,
  output cip_pkg::out_item_t  result
);

  localparam int W = cip_pkg::CoordW;
  localparam int R = cip_pkg::MaxRegions;
  localparam int H = cip_pkg::HistDepth;

  logic [W-1:0] rstart [R];
  logic [W-1:0] rend [R];
  logic [W-1:0] qsf [R];
  logic [W-1:0] qef [R];
  logic [4:0]   bse [R];
  logic [R-1:0] sloc, eloc, done;
  logic [W-1:0] hist [H];
  logic [W-1:0] tcur, qcur, pqe, bpq, bts, bqs, bte, bqe;
  logic         begun;
  logic [3:0]   sh;

  assign sh = cfg.flank;

  // load resolution
  logic [W-1:0] lb, le, ls, lx;
  logic         l_out, l_lo, l_hi;
  always_comb begin
    lb = (item.region_begin > item.region_finish) ? item.region_finish : item.region_begin;
    le = (item.region_begin > item.region_finish) ? item.region_begin : item.region_finish;
    l_out = !item.same_chromosome;
    l_lo = !l_out && (le < cfg.tstart);
    l_hi = !l_out && !l_lo && (lb > cfg.tend);
    ls = cfg.qfwd ? cfg.qstart : cip_pkg::sat_sub(cfg.qlen, cfg.qend);
    lx = cfg.qfwd ? cfg.qend : cip_pkg::sat_sub(cfg.qlen, cfg.qstart);
  end

  // one region update per scan cycle
  logic [4:0]   i;
  logic [W-1:0] rs, re;
  logic         s_l, e_l, d_n;
  logic [W-1:0] qs_n, qe_n;
  logic [4:0]   b_n;
  always_comb begin
    i = cmd.idx;
    rs = rstart[i];
    re = rend[i];
    s_l = sloc[i];
    e_l = eloc[i];
    d_n = done[i];
    qs_n = qsf[i];
    qe_n = qef[i];
    b_n = bse[i];
    if (!done[i]) begin
      if (!s_l && bts > rs) begin
        s_l = 1'b1;
        qs_n = (sh == 4'd0) ? bqs : hist[5'(sh) + 5'd1];
      end else if (!s_l && bte > rs) begin
        s_l = 1'b1;
        qs_n = (sh == 4'd0) ? cip_pkg::sat_add(bqs, rs - bts) : hist[5'(sh)];
      end
      if (sh != 4'd0) begin
        if (s_l && !e_l && bte > re) begin
          e_l = 1'b1;
          b_n = '0;
        end
        if (e_l) begin
          if (b_n >= 5'(sh)) begin
            qe_n = bqe;
            d_n = 1'b1;
          end else begin
            b_n = b_n + 5'd1;
          end
        end
      end else if (s_l && !e_l) begin
        if (bts > re) begin
          e_l = 1'b1;
          qe_n = bpq;
          d_n = 1'b1;
        end else if (bte >= re) begin
          e_l = 1'b1;
          qe_n = cip_pkg::sat_add(bqs, re - bts);
          d_n = 1'b1;
        end
      end
    end
  end

  // report
  logic [W-1:0] os, oe;
  always_comb begin
    oe = (qef[i] == '0) ? cfg.qend : qef[i];
    os = (qsf[i] == '0) ? cfg.qstart : qsf[i];
    result.region_number = i;
    result.last_result = last;
    if (!cfg.qfwd) begin
      result.projected_start = cip_pkg::sat_sub(cfg.qlen, oe);
      result.projected_end = cip_pkg::sat_sub(cfg.qlen, os);
    end else begin
      result.projected_start = os;
      result.projected_end = oe;
    end
  end

  logic [W-1:0] ts0, qs0;
  assign ts0 = begun ? tcur : cfg.tstart;
  assign qs0 = begun ? qcur : cfg.qstart;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sloc <= '0;
      eloc <= '0;
      done <= '0;
      begun <= 1'b0;
      tcur <= '0;
      qcur <= '0;
      pqe <= '0;
      for (int k = 0; k < R; k++) begin
        qsf[k] <= '0;
        qef[k] <= '0;
        bse[k] <= '0;
      end
      for (int k = 0; k < H; k++) hist[k] <= '0;
    end else begin
      if (cmd.load) begin
        rstart[item.region_slot] <= lb;
        rend[item.region_slot] <= le;
        bse[item.region_slot] <= '0;
        qsf[item.region_slot] <= l_lo ? ls : l_hi ? cip_pkg::sat_sub(lx, 31'd1) : '0;
        qef[item.region_slot] <= l_lo ? cip_pkg::sat_add(ls, 31'd1) : l_hi ? lx : '0;
        done[item.region_slot] <= l_out || l_lo || l_hi;
        sloc[item.region_slot] <= l_out || l_lo || l_hi;
        eloc[item.region_slot] <= l_out || l_lo || l_hi;
      end
      if (cmd.block) begin
        // latch block bounds, then step cursors and history
        begun <= 1'b1;
        bts <= ts0;
        bqs <= qs0;
        bte <= cip_pkg::sat_add(ts0, item.block_length);
        bqe <= cip_pkg::sat_add(qs0, item.block_length);
        tcur <= cip_pkg::sat_add(cip_pkg::sat_add(ts0, item.block_length), item.target_gap);
        qcur <= cip_pkg::sat_add(cip_pkg::sat_add(qs0, item.block_length), item.query_gap);
        // hold the previous block's query end for the sweep
        bpq <= begun ? pqe : cfg.qstart;
        pqe <= cip_pkg::sat_add(qs0, item.block_length);
        for (int k = H - 1; k >= 1; k--) hist[k] <= hist[k-1];
        hist[0] <= qs0;
      end
      if (cmd.scan) begin
        sloc[i] <= s_l;
        eloc[i] <= e_l;
        done[i] <= d_n;
        qsf[i] <= qs_n;
        qef[i] <= qe_n;
        bse[i] <= b_n;
      end
    end
  end

  a_done_located: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && d_n) |=> (sloc[$past(i)] && eloc[$past(i)]))
    else $error("done region without located ends");
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (done == '0 && !begun))
    else $error("clear left state");
  a_block_begins: assert property (@(posedge clk) disable iff (rst)
    cmd.block |=> begun)
    else $error("block did not start chain");

endmodule

// ----- rtl/core/chain_interval_projector.sv -----
// Top level of the chain interval projector: config registers, controller, datapath.
// Depends on cip_pkg, cip_ctrl and cip_dp.
// Block: block state, then a scan of N = min(region_count, 32) regions, one region a cycle.
// Finish: one result per cycle when not stalled, N results, then the clear state.
// One item at a time; stall is high whenever the controller is not idle (block, sweep, report, clear).
// Synchronous active-high rst clears controller, cursors, history and region flags; config to reset values.
module chain_interval_projector (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cip_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cip_pkg::out_item_t    out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [30:0]           cfg_data
);

  cip_pkg::cfg_t cfg;
  cip_pkg::cmd_t cmd;
  logic          last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flank <= 4'd2;
      cfg.count <= '0;
      cfg.tstart <= '0;
      cfg.tend <= '0;
      cfg.qstart <= '0;
      cfg.qend <= '0;
      cfg.qlen <= '0;
      cfg.qfwd <= 1'b1;
    end else if (cfg_we) begin
      unique case (cip_pkg::reg_idx_t'(cfg_index))
        cip_pkg::REG_FLANK:  cfg.flank <= cfg_data[3:0];
        cip_pkg::REG_COUNT:  cfg.count <= cfg_data[5:0];
        cip_pkg::REG_TSTART: cfg.tstart <= cfg_data;
        cip_pkg::REG_TEND:   cfg.tend <= cfg_data;
        cip_pkg::REG_QSTART: cfg.qstart <= cfg_data;
        cip_pkg::REG_QEND:   cfg.qend <= cfg_data;
        cip_pkg::REG_QLEN:   cfg.qlen <= cfg_data;
        cip_pkg::REG_QFWD:   cfg.qfwd <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cip_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_mode(in_data.mode), .in_stall(in_stall),
    .count(cfg.count),
    .out_valid(out_valid), .out_stall(out_stall), .out_last(last),
    .cmd(cmd)
  );

  cip_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg(cfg), .item(in_data),
    .last(last), .result(out_data)
  );

endmodule

// ----- dv/tb_top.sv -----
// Testbench for chain_interval_projector: directed and random item streams
// checked against an in-bench projection predictor. Depends on cip_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2000000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  cip_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  cip_pkg::out_item_t out_data;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  chain_interval_projector dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [3:0] p_flank;
  logic [5:0] p_count;
  logic [30:0] p_tstart, p_tend, p_qstart, p_qend, p_qlen;
  logic p_qfwd;
  logic [30:0] r_start [cip_pkg::MaxRegions], r_end [cip_pkg::MaxRegions];
  logic s_loc [cip_pkg::MaxRegions], e_loc [cip_pkg::MaxRegions];
  logic r_done [cip_pkg::MaxRegions];
  logic [30:0] qs_found [cip_pkg::MaxRegions], qe_found [cip_pkg::MaxRegions];
  logic [4:0] since_end [cip_pkg::MaxRegions];
  logic [30:0] qs_hist [cip_pkg::HistDepth];
  logic [30:0] t_cur, q_cur, prev_qe;
  logic begun;

  cip_pkg::out_item_t projections[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  longint cycles = 0;
  bit hold_off = 0;
  bit rand_stall = 1;

  function automatic logic [30:0] add_sat(logic [30:0] a, logic [30:0] b);
    logic [31:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[31] ? 31'h7fffffff : s[30:0];
  endfunction

  function automatic logic [30:0] sub_sat(logic [30:0] a, logic [30:0] b);
    return a > b ? a - b : 31'd0;
  endfunction

  function automatic int live_regions();
    return p_count > cip_pkg::MaxRegions ? cip_pkg::MaxRegions : int'(p_count);
  endfunction

  task automatic clear_pred();
    for (int i = 0; i < cip_pkg::MaxRegions; i++) begin
      r_start[i] = 0; r_end[i] = 0; s_loc[i] = 0; e_loc[i] = 0; r_done[i] = 0;
      qs_found[i] = 0; qe_found[i] = 0; since_end[i] = 0;
    end
    for (int k = 0; k < cip_pkg::HistDepth; k++) qs_hist[k] = 0;
    t_cur = 0; q_cur = 0; prev_qe = 0; begun = 0;
  endtask

  task automatic predict_load(cip_pkg::in_item_t it);
    logic [30:0] b, e, x;
    int s;
    s = int'(it.region_slot);
    b = it.region_begin; e = it.region_finish;
    if (b > e) begin
      x = b; b = e; e = x;
    end
    r_start[s] = b; r_end[s] = e;
    s_loc[s] = 0; e_loc[s] = 0; r_done[s] = 0;
    qs_found[s] = 0; qe_found[s] = 0; since_end[s] = 0;
    if (!it.same_chromosome) r_done[s] = 1;
    else if (e < p_tstart) begin
      x = p_qfwd ? p_qstart : sub_sat(p_qlen, p_qend);
      qs_found[s] = x; qe_found[s] = add_sat(x, 31'd1); r_done[s] = 1;
    end else if (b > p_tend) begin
      x = p_qfwd ? p_qend : sub_sat(p_qlen, p_qstart);
      qe_found[s] = x; qs_found[s] = sub_sat(x, 31'd1); r_done[s] = 1;
    end
    if (r_done[s]) begin
      s_loc[s] = 1; e_loc[s] = 1;
    end
  endtask

  task automatic predict_block(cip_pkg::in_item_t it);
    logic [30:0] bts, bqs, bte, bqe, rs, re;
    int sh;
    if (!begun) begin
      t_cur = p_tstart; q_cur = p_qstart; prev_qe = p_qstart; begun = 1;
    end
    bts = t_cur; bqs = q_cur;
    bte = add_sat(bts, it.block_length); bqe = add_sat(bqs, it.block_length);
    t_cur = add_sat(bte, it.target_gap);
    q_cur = add_sat(bqe, it.query_gap);
    for (int k = cip_pkg::HistDepth - 1; k >= 1; k--) qs_hist[k] = qs_hist[k-1];
    qs_hist[0] = bqs;
    sh = int'(p_flank);
    for (int i = 0; i < live_regions(); i++) begin
      rs = r_start[i]; re = r_end[i];
      if (r_done[i]) continue;
      if (!s_loc[i] && bts > rs) begin
        s_loc[i] = 1;
        qs_found[i] = sh == 0 ? bqs : qs_hist[sh+1];
      end else if (!s_loc[i] && bte > rs) begin
        s_loc[i] = 1;
        qs_found[i] = sh == 0 ? add_sat(bqs, rs - bts) : qs_hist[sh];
      end
      if (sh > 0) begin
        if (s_loc[i] && !e_loc[i] && bte > re) begin
          e_loc[i] = 1; since_end[i] = 0;
        end
        if (e_loc[i]) begin
          if (since_end[i] >= sh) begin
            qe_found[i] = bqe; r_done[i] = 1;
          end else since_end[i] = since_end[i] + 5'd1;
        end
      end else if (s_loc[i] && !e_loc[i]) begin
        if (bts > re) begin
          e_loc[i] = 1; qe_found[i] = prev_qe; r_done[i] = 1;
        end else if (bte >= re) begin
          e_loc[i] = 1; qe_found[i] = add_sat(bqs, re - bts); r_done[i] = 1;
        end
      end
    end
    prev_qe = bqe;
  endtask

  task automatic predict_finish();
    cip_pkg::out_item_t r;
    logic [30:0] s, e, t;
    int n;
    n = live_regions();
    for (int i = 0; i < n; i++) begin
      s = qs_found[i]; e = qe_found[i];
      if (e == 0) e = p_qend;
      if (s == 0) s = p_qstart;
      if (!p_qfwd) begin
        t = s; s = sub_sat(p_qlen, e); e = sub_sat(p_qlen, t);
      end
      r.region_number = 5'(i);
      r.projected_start = s;
      r.projected_end = e;
      r.last_result = (i + 1 == n);
      projections.push_back(r);
    end
    clear_pred();
  endtask

  task automatic send_item(cip_pkg::in_item_t it);
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    case (cip_pkg::mode_t'(it.mode))
      cip_pkg::MODE_LOAD: predict_load(it);
      cip_pkg::MODE_BLOCK: predict_block(it);
      cip_pkg::MODE_FINISH: predict_finish();
      default: ;
    endcase
    // burst gap
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    in_valid <= 0;
    @(posedge clk);
    while (projections.size() != 0) @(posedge clk);
    repeat (2 * cip_pkg::MaxRegions + 8) @(posedge clk);
  endtask

  task automatic write_reg(cip_pkg::reg_idx_t idx, logic [30:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      cip_pkg::REG_FLANK: p_flank = v[3:0];
      cip_pkg::REG_COUNT: p_count = v[5:0];
      cip_pkg::REG_TSTART: p_tstart = v;
      cip_pkg::REG_TEND: p_tend = v;
      cip_pkg::REG_QSTART: p_qstart = v;
      cip_pkg::REG_QEND: p_qend = v;
      cip_pkg::REG_QLEN: p_qlen = v;
      default: p_qfwd = v[0];
    endcase
  endtask

  task automatic setup_chain(int flank, int count, int ts, int te, int qs, int qe, int ql,
                             int fwd);
    write_reg(cip_pkg::REG_FLANK, 31'(flank));
    write_reg(cip_pkg::REG_COUNT, 31'(count));
    write_reg(cip_pkg::REG_TSTART, 31'(ts));
    write_reg(cip_pkg::REG_TEND, 31'(te));
    write_reg(cip_pkg::REG_QSTART, 31'(qs));
    write_reg(cip_pkg::REG_QEND, 31'(qe));
    write_reg(cip_pkg::REG_QLEN, 31'(ql));
    write_reg(cip_pkg::REG_QFWD, 31'(fwd));
  endtask

  function automatic cip_pkg::in_item_t load_item(int slot, int b, int e, bit same);
    cip_pkg::in_item_t it;
    it = '0;
    it.mode = cip_pkg::MODE_LOAD; it.region_slot = 5'(slot);
    it.region_begin = 31'(b); it.region_finish = 31'(e); it.same_chromosome = same;
    it.block_length = 31'($urandom); it.target_gap = 31'($urandom);
    it.query_gap = 31'($urandom);
    return it;
  endfunction

  function automatic cip_pkg::in_item_t block_item(int len, int tg, int qg);
    cip_pkg::in_item_t it;
    it = '0;
    it.mode = cip_pkg::MODE_BLOCK; it.block_length = 31'(len);
    it.target_gap = 31'(tg); it.query_gap = 31'(qg);
    it.region_slot = 5'($urandom); it.region_begin = 31'($urandom);
    it.region_finish = 31'($urandom);
    it.same_chromosome = 1'($urandom);
    return it;
  endfunction

  function automatic cip_pkg::in_item_t finish_item();
    cip_pkg::in_item_t it;
    it = '0;
    it.mode = cip_pkg::MODE_FINISH;
    return it;
  endfunction

  // load every active slot so no unwritten region is ever read
  task automatic load_all(int n, int lo, int span);
    for (int i = 0; i < n; i++)
      send_item(load_item(i, lo + int'($urandom_range(0, span)),
                          lo + int'($urandom_range(0, span)),
                          $urandom_range(0, 7) != 0));
  endtask

  task automatic test_directed();
    cip_pkg::in_item_t it;
    setup_chain(0, 4, 100, 1000, 50, 900, 2000, 1);
    send_item(load_item(0, 200, 150, 1));
    send_item(load_item(1, 10, 20, 1));          // before chain start
    send_item(load_item(2, 1500, 1600, 1));      // beyond chain end
    send_item(load_item(3, 300, 400, 0));        // other chromosome
    send_item(load_item(31, 0, 31'h7fffffff, 1));
    send_item(block_item(120, 30, 20));
    send_item(block_item(200, 10, 10));
    it = finish_item(); it.mode = cip_pkg::MODE_NONE;
    send_item(it);
    send_item(finish_item());
    go_idle();
    setup_chain(15, 32, 0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 0);
    load_all(32, 0, 31'h7fffffff);
    send_item(block_item(31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
    send_item(block_item(0, 0, 0));
    send_item(finish_item());
    go_idle();
    write_reg(cip_pkg::REG_COUNT, 31'd0);
    send_item(finish_item());
    go_idle();
  endtask

  task automatic test_random_chains(int items);
    int n, nb;
    while (items_sent < items) begin
      n = $urandom_range(0, 9) == 0 ? $urandom_range(33, 63) : $urandom_range(1, 8);
      setup_chain($urandom_range(0, 15), n, $urandom_range(0, 500), $urandom_range(3000, 6000),
                  $urandom_range(0, 1000), $urandom_range(2000, 9000),
                  $urandom_range(0, 12000), $urandom_range(0, 1));
      load_all(n > cip_pkg::MaxRegions ? cip_pkg::MaxRegions : n, 0, 7000);
      nb = $urandom_range(2, 20);
      for (int b = 0; b < nb; b++) begin
        if ($urandom_range(0, 15) == 0) send_item(load_item($urandom, $urandom, $urandom, 0));
        send_item(block_item($urandom_range(0, 400), $urandom_range(0, 200),
                             $urandom_range(0, 200)));
      end
      send_item(finish_item());
      go_idle();
    end
  endtask

  task automatic test_backpressure();
    setup_chain(1, 32, 0, 9000, 10, 9000, 9000, 1);
    load_all(32, 0, 5000);
    hold_off = 1;
    send_item(finish_item());
    send_item(block_item(100, 5, 5));
    send_item(finish_item());
    go_idle();
  endtask

  // receiver stall pattern; a long hold-off when asked, released after it runs out
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1;
        for (hold = 0; hold < 300; hold++) @(posedge clk);
        hold_off = 0;
        out_stall <= 0;
      end else if (rand_stall) out_stall <= ($urandom_range(0, 2) == 0);
      else out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    cip_pkg::out_item_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL chain_interval_projector");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (projections.size() == 0) begin
        $error("result with nothing expected: %p", out_data);
        errors++;
      end else begin
        exp_r = projections.pop_front();
        results_seen++;
        if (out_data.region_number !== exp_r.region_number) begin
          $error("region_number exp %0d got %0d", exp_r.region_number, out_data.region_number);
          errors++;
        end
        if (out_data.projected_start !== exp_r.projected_start) begin
          $error("projected_start exp %0d got %0d", exp_r.projected_start,
                 out_data.projected_start);
          errors++;
        end
        if (out_data.projected_end !== exp_r.projected_end) begin
          $error("projected_end exp %0d got %0d", exp_r.projected_end, out_data.projected_end);
          errors++;
        end
        if (out_data.last_result !== exp_r.last_result) begin
          $error("last_result exp %0d got %0d", exp_r.last_result, out_data.last_result);
          errors++;
        end
      end
    end
  end

  initial begin
    p_flank = 2; p_count = 0; p_tstart = 0; p_tend = 0; p_qstart = 0; p_qend = 0;
    p_qlen = 0; p_qfwd = 1;
    clear_pred();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    rand_stall = 0;
    test_random_chains(items_sent + 20);
    rand_stall = 1;
    test_random_chains(items_sent + 45);
    go_idle();
    if (projections.size() != 0) begin
      $error("%0d projections never arrived", projections.size());
      errors++;
    end
    $display("Covered %0d items and %0d projected regions over loads, blocks and reports,",
             items_sent, results_seen);
    $display("with both strands, all flank widths and output back-pressure.");
    if (errors == 0) $display("PASS chain_interval_projector");
    else $display("FAIL chain_interval_projector");
    $finish;
  end
endmodule
